/* rtl/pai_pkg.sv */
// Shared constants and types for the positional array insert/delete store.
`timescale 1ns / 1ps
package pai_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_DELETE  = 2'd1;
  localparam logic [1:0] ACT_DISPLAY = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic [CNT_W-1:0]         count;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

endpackage

/* rtl/pai_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pai_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6,
  parameter int DEPTH  = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/pai_seq.sv */
// Operation sequencer: decodes commands, walks the store to shift or display entries.
`timescale 1ns / 1ps
module pai_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [pai_pkg::POS_W-1:0]     in_pos,
  input  logic [pai_pkg::DATA_W-1:0]    in_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pai_pkg::res_t                 res,
  output pai_pkg::ram_req_t             ram_req,
  input  logic [pai_pkg::DATA_W-1:0]    ram_rd_data
);
  import pai_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT_VAL,
    S_SHIFT_DN,
    S_DISP,
    S_REPORT
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [POS_W-1:0]  op_pos, op_pos_next;
  logic [DATA_W-1:0] op_val, op_val_next;
  status_t           status_r, status_next;

  logic [CNT_W-1:0] cnt_m1, idx_m1, idx_m2, idx_p1, idx_p2, pos_p1;
  logic             disp_last;

  assign cnt_m1    = count - CNT_W'(1);
  assign idx_m1    = idx - CNT_W'(1);
  assign idx_m2    = idx - CNT_W'(2);
  assign idx_p1    = idx + CNT_W'(1);
  assign idx_p2    = idx + CNT_W'(2);
  assign pos_p1    = CNT_W'(in_pos) + CNT_W'(1);
  assign disp_last = (idx_p1 == count);

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    op_pos_next = op_pos;
    op_val_next = op_val;
    status_next = status_r;
    ram_req     = '0;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    res.status  = status_r;
    res.value   = '0;
    res.last    = 1'b1;
    res.count   = count;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_pos_next = in_pos;
          op_val_next = in_value;
          state_next  = S_REPORT;
          status_next = ST_OK;
          case (in_action)
            ACT_INSERT: begin
              if (count >= DEPTH_CNT) begin
                status_next = ST_FULL;
              end else if (CNT_W'(in_pos) > count) begin
                status_next = ST_BADPOS;
              end else if (CNT_W'(in_pos) == count) begin
                state_next = S_PUT_VAL;
              end else begin
                idx_next        = count;
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = cnt_m1[ADDR_W-1:0];
                state_next      = S_SHIFT_UP;
              end
            end
            ACT_DELETE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else if (CNT_W'(in_pos) >= count) begin
                status_next = ST_BADPOS;
              end else if (pos_p1 == count) begin
                count_next = cnt_m1;
              end else begin
                idx_next        = CNT_W'(in_pos);
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = pos_p1[ADDR_W-1:0];
                state_next      = S_SHIFT_DN;
              end
            end
            ACT_DISPLAY: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                idx_next        = '0;
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = '0;
                state_next      = S_DISP;
              end
            end
            default: begin
              status_next = ST_BADPOS;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx[ADDR_W-1:0];
        ram_req.wr_data = ram_rd_data;
        if (idx_m1 == CNT_W'(op_pos)) begin
          state_next = S_PUT_VAL;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx_m2[ADDR_W-1:0];
          idx_next        = idx_m1;
        end
      end
      S_PUT_VAL: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = op_pos[ADDR_W-1:0];
        ram_req.wr_data = op_val;
        count_next      = count + CNT_W'(1);
        status_next     = ST_OK;
        state_next      = S_REPORT;
      end
      S_SHIFT_DN: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx[ADDR_W-1:0];
        ram_req.wr_data = ram_rd_data;
        if (idx_p2 == count) begin
          count_next  = cnt_m1;
          status_next = ST_OK;
          state_next  = S_REPORT;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx_p2[ADDR_W-1:0];
          idx_next        = idx_p1;
        end
      end
      S_DISP: begin
        res_valid  = 1'b1;
        res.status = ST_OK;
        res.value  = ram_rd_data;
        res.last   = disp_last;
        if (res_ready) begin
          if (disp_last) begin
            state_next = S_IDLE;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_p1[ADDR_W-1:0];
            idx_next        = idx_p1;
          end
        end
      end
      S_REPORT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      idx      <= '0;
      status_r <= ST_OK;
    end else begin
      state    <= state_next;
      count    <= count_next;
      idx      <= idx_next;
      status_r <= status_next;
    end
    op_pos <= op_pos_next;
    op_val <= op_val_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> in_ready)
    else $error("sequencer not idle after final word");

  a_no_write_on_display: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP || state == S_REPORT || state == S_IDLE) |-> !ram_req.wr_en)
    else $error("store written outside an update");

endmodule

/* rtl/positional_array_insert_delete_core.sv */
// Top level: stream ports, entry store, sequencer and output register.
`timescale 1ns / 1ps
// Ordered store of up to 64 signed 32-bit entries. Each command word is taken
// only once the sequencer has finished the previous one. After the accept
// cycle, an insert at position p with n entries held makes one shift step per
// moved entry and then the final write. A delete makes one shift step per
// entry above p. A rejected command does neither. Each of these then ends
// with a final report before the next command is taken. A display fetches the
// first entry and then sends one word per cycle while the output register can
// take it, with no separate report. The shift walk through the single-write,
// single-read entry RAM moves one entry per cycle. The sequencer waits on a
// result while the output register is full and m_tready is low.
// Result words pass through an output register, so the last result can wait
// on m_tready while the next command is accepted.
module positional_array_insert_delete_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], new_value[38:7], zero pad
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // entry_value[31:0], entry_count[38:32], zero pad
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);
  import pai_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rd_data;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_word;

  pai_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  pai_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_action   (s_tuser),
    .in_pos      (s_tdata[POS_W-1:0]),
    .in_value    (s_tdata[POS_W+DATA_W-1:POS_W]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign m_tdata = {1'b0, out_word.count, out_word.value};
  assign m_tuser = out_word.status;
  assign m_tlast = out_word.last;

endmodule
